FILE: hdl/nst_pkg.sv
`default_nettype none
package nst_pkg;
    localparam int MAX_PLANES    = 32;
    localparam int MAX_PER_PLANE = 32;
    localparam int COORD_BITS    = 26;
    localparam int PL_W    = $clog2(MAX_PLANES);
    localparam int SL_W    = $clog2(MAX_PER_PLANE);
    localparam int SLOTS   = MAX_PLANES * MAX_PER_PLANE;
    localparam int IDX_W   = PL_W + SL_W;
    localparam int CNT_W   = 11;
    localparam int DIST_W  = 54;
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int SQ_W    = 2 * COORD_BITS;
    localparam int CFG_W   = 6;
    localparam int MEM_W   = 3 * COORD_BITS + 1;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_UPDATE = 2'd1,
        OP_READ   = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OCCUPIED = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_RANGE    = 2'd3
    } status_t;

    localparam logic [0:0] CFG_PLANES = 1'b0;
    localparam logic [0:0] CFG_SLOTS  = 1'b1;

    // candidate word handed from cell to cell
    typedef struct packed {
        logic                          valid;
        logic [PL_W-1:0]               plane;
        logic [SL_W-1:0]               slot;
        logic signed [COORD_BITS-1:0]  x;
        logic signed [COORD_BITS-1:0]  y;
        logic signed [COORD_BITS-1:0]  z;
    } cand_t;

    // running best carried through the compare chain
    typedef struct packed {
        logic                          found;
        logic [PL_W-1:0]               plane;
        logic [SL_W-1:0]               slot;
        logic signed [COORD_BITS-1:0]  x;
        logic signed [COORD_BITS-1:0]  y;
        logic signed [COORD_BITS-1:0]  z;
        logic [DIST_W-1:0]             sq_dist;
    } best_t;
endpackage
`default_nettype wire

FILE: hdl/nearest_satellite_table_unit.sv
`default_nettype none
// Nearest-satellite table: 32 planes x 32 slots of signed 26-bit positions in
// block RAM, each RAM word carrying its occupied mark beside the position.
// After reset a clearing pass wipes the RAM one word a cycle, so s_ready stays
// low until every word is clear. Add, update and read take one RAM read and at
// most one write: the request passes S_RD, S_EXEC and S_OUT before the result
// word is loaded into the output register. A nearest query reads one slot a
// cycle, plane-major, through a chain of three squaring cells and a compare
// cell: it scans planes_in_use x slots_per_plane slots (none if either is
// zero), then drains the chain and hands the word to the output register.
// The scan rate is set by the single RAM read port. A finished word waits in
// the output register while the next item is worked on; the block only stalls
// its input further when a second result is ready before the first has been
// taken. Write configuration only while idle; values above 32 saturate, zero
// puts every slot out of range.
module nearest_satellite_table_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [0:0]                        cfg_index,
    input  wire logic [nst_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [1:0]                        s_op,
    input  wire logic [4:0]                        s_sel_plane,
    input  wire logic [4:0]                        s_sel_slot,
    input  wire logic signed [25:0]                s_px,
    input  wire logic signed [25:0]                s_py,
    input  wire logic signed [25:0]                s_pz,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [1:0]                             m_status,
    output logic                                   m_found,
    output logic [4:0]                             m_hit_plane,
    output logic [4:0]                             m_hit_slot,
    output logic signed [25:0]                     m_hit_x,
    output logic signed [25:0]                     m_hit_y,
    output logic signed [25:0]                     m_hit_z,
    output logic [53:0]                            m_best_sq_distance,
    output logic [10:0]                            m_sat_count
);
    import nst_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_RD, S_EXEC, S_SCAN, S_DRAIN, S_OUT
    } state_t;
    localparam int DRAIN = 5;

    // configuration
    logic [CFG_W-1:0] planes_reg, slots_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            planes_reg <= CFG_W'(MAX_PLANES);
            slots_reg  <= CFG_W'(MAX_PER_PLANE);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PLANES: planes_reg <= cfg_data;
                CFG_SLOTS:  slots_reg  <= cfg_data;
                default: ;
            endcase
        end
    end
    logic [CFG_W-1:0] np, ns;
    assign np = (planes_reg > CFG_W'(MAX_PLANES)) ? CFG_W'(MAX_PLANES) : planes_reg;
    assign ns = (slots_reg > CFG_W'(MAX_PER_PLANE)) ? CFG_W'(MAX_PER_PLANE) : slots_reg;

    // position store, top bit of each word is the occupied mark
    logic [MEM_W-1:0] mem [SLOTS];
    logic [MEM_W-1:0] rd_data;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic             wr_en;
    logic [MEM_W-1:0] wr_data;
    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

    state_t state_reg;
    op_t    op_reg;
    logic [PL_W-1:0] pl_reg, scan_p_reg;
    logic [SL_W-1:0] sl_reg, scan_s_reg;
    logic signed [COORD_BITS-1:0] qx_reg, qy_reg, qz_reg;
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] clr_reg;
    logic [2:0] drain_reg;
    logic rng_reg;
    cand_t feed_reg;
    logic [PL_W-1:0] feed_p_next;

    // result word being built
    logic [1:0] o_status_reg;
    logic o_found_reg;
    logic [PL_W-1:0] o_pl_reg;
    logic [SL_W-1:0] o_sl_reg;
    logic signed [COORD_BITS-1:0] o_x_reg, o_y_reg, o_z_reg;
    logic [DIST_W-1:0] o_d_reg;

    // output register
    logic o_valid_reg;
    logic [1:0] out_status_reg;
    logic out_found_reg;
    logic [PL_W-1:0] out_pl_reg;
    logic [SL_W-1:0] out_sl_reg;
    logic signed [COORD_BITS-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic [DIST_W-1:0] out_d_reg;
    logic [CNT_W-1:0] out_cnt_reg;
    logic out_load;

    logic rd_occ, add_ok, read_hit;
    assign rd_occ   = rd_data[MEM_W-1];
    assign add_ok   = rng_reg && (op_reg == OP_ADD) && !rd_occ;
    assign read_hit = rng_reg && (op_reg == OP_READ) && rd_occ;

    logic [IDX_W-1:0] sel_idx, scan_idx;
    assign sel_idx  = {pl_reg, sl_reg};
    assign scan_idx = {scan_p_reg, scan_s_reg};
    assign rd_addr  = (state_reg == S_SCAN) ? scan_idx : sel_idx;
    assign wr_addr  = (state_reg == S_CLEAR) ? clr_reg : sel_idx;
    assign wr_data  = (state_reg == S_CLEAR) ? '0 : {1'b1, qx_reg, qy_reg, qz_reg};
    assign wr_en    = (state_reg == S_CLEAR) ||
                      ((state_reg == S_EXEC) && rng_reg &&
                       ((op_reg == OP_ADD && !rd_occ) ||
                        (op_reg == OP_UPDATE && rd_occ)));

    assign s_ready = (state_reg == S_IDLE);
    assign feed_p_next = scan_p_reg;
    assign out_load = (state_reg == S_OUT) && (!o_valid_reg || m_ready);

    // compare chain: three squaring cells then a compare cell
    cand_t c0, c1, c2, c3;
    logic [DIST_W-1:0] s1, s2, s3;
    assign c0 = '{valid: feed_reg.valid && rd_occ, plane: feed_reg.plane,
                  slot: feed_reg.slot,
                  x: rd_data[3*COORD_BITS-1:2*COORD_BITS],
                  y: rd_data[2*COORD_BITS-1:COORD_BITS],
                  z: rd_data[COORD_BITS-1:0]};
    nst_sq_cell u_cx (.aclk, .a(c0.x), .b(qx_reg), .sum_in('0), .cand_in(c0),
                      .sum_out(s1), .cand_out(c1));
    nst_sq_cell u_cy (.aclk, .a(c1.y), .b(qy_reg), .sum_in(s1), .cand_in(c1),
                      .sum_out(s2), .cand_out(c2));
    nst_sq_cell u_cz (.aclk, .a(c2.z), .b(qz_reg), .sum_in(s2), .cand_in(c2),
                      .sum_out(s3), .cand_out(c3));
    best_t best;
    nst_cmp_cell u_cmp (.aclk, .aresetn, .clear(s_valid && s_ready), .cand(c3),
                        .sq_dist(s3), .best);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            count_reg   <= '0;
            o_valid_reg <= 1'b0;
            feed_reg    <= '0;
        end else begin
            if (state_reg != S_SCAN) feed_reg.valid <= 1'b0;
            // hand the finished word to the output register once it is free
            if (out_load) begin
                o_valid_reg    <= 1'b1;
                out_status_reg <= o_status_reg;
                out_found_reg  <= o_found_reg;
                out_pl_reg     <= o_pl_reg;
                out_sl_reg     <= o_sl_reg;
                out_x_reg      <= o_x_reg;
                out_y_reg      <= o_y_reg;
                out_z_reg      <= o_z_reg;
                out_d_reg      <= o_d_reg;
                out_cnt_reg    <= count_reg;
            end else if (o_valid_reg && m_ready) begin
                o_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    // wipe one word a cycle so every mark starts clear
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == '1) state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg <= op_t'(s_op);
                        pl_reg <= s_sel_plane;
                        sl_reg <= s_sel_slot;
                        qx_reg <= s_px;
                        qy_reg <= s_py;
                        qz_reg <= s_pz;
                        scan_p_reg <= '0;
                        scan_s_reg <= '0;
                        state_reg <= (op_t'(s_op) == OP_QUERY) ? S_SCAN : S_RD;
                    end
                end
                S_RD: begin
                    // hold the address while the store word is fetched
                    rng_reg <= ({1'b0, pl_reg} < np) && ({1'b0, sl_reg} < ns);
                    state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    if (!rng_reg) o_status_reg <= ST_RANGE;
                    else if (op_reg == OP_ADD) o_status_reg <= rd_occ ? ST_OCCUPIED : ST_OK;
                    else if (!rd_occ) o_status_reg <= ST_EMPTY;
                    else o_status_reg <= ST_OK;
                    if (add_ok) count_reg <= count_reg + 1'b1;
                    o_found_reg <= read_hit;
                    o_pl_reg <= read_hit ? pl_reg : '0;
                    o_sl_reg <= read_hit ? sl_reg : '0;
                    o_x_reg <= read_hit ? rd_data[3*COORD_BITS-1:2*COORD_BITS] : '0;
                    o_y_reg <= read_hit ? rd_data[2*COORD_BITS-1:COORD_BITS] : '0;
                    o_z_reg <= read_hit ? rd_data[COORD_BITS-1:0] : '0;
                    o_d_reg <= '0;
                    state_reg <= S_OUT;
                end
                S_SCAN: begin
                    // advance plane-major; feed is registered with the RAM read, so it tags the word in rd_data
                    if (np == '0 || ns == '0) begin
                        feed_reg.valid <= 1'b0;
                        state_reg <= S_DRAIN;
                    end else begin
                        feed_reg.valid <= 1'b1;
                        feed_reg.plane <= feed_p_next;
                        feed_reg.slot  <= scan_s_reg;
                        if ({1'b0, scan_s_reg} == ns - 1'b1) begin
                            scan_s_reg <= '0;
                            if ({1'b0, scan_p_reg} == np - 1'b1) state_reg <= S_DRAIN;
                            else scan_p_reg <= scan_p_reg + 1'b1;
                        end else begin
                            scan_s_reg <= scan_s_reg + 1'b1;
                        end
                    end
                    drain_reg <= '0;
                end
                S_DRAIN: begin
                    drain_reg <= drain_reg + 1'b1;
                    if (drain_reg == 3'(DRAIN - 1)) begin
                        o_status_reg <= ST_OK;
                        o_found_reg  <= best.found;
                        o_pl_reg <= best.plane; o_sl_reg <= best.slot;
                        o_x_reg <= best.x; o_y_reg <= best.y; o_z_reg <= best.z;
                        o_d_reg <= best.sq_dist;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!o_valid_reg || m_ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // the word waits in the output register while the next item is taken
    assign m_valid            = o_valid_reg;
    assign m_status           = out_status_reg;
    assign m_found            = out_found_reg;
    assign m_hit_plane        = out_pl_reg;
    assign m_hit_slot         = out_sl_reg;
    assign m_hit_x            = out_x_reg;
    assign m_hit_y            = out_y_reg;
    assign m_hit_z            = out_z_reg;
    assign m_best_sq_distance = out_d_reg;
    assign m_sat_count        = out_cnt_reg;

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != $past(count_reg) |-> $past(wr_en) && $past(op_reg) == OP_ADD)
        else $error("count moved without an add");
    a_notfound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_best_sq_distance == '0)
        else $error("distance without a hit");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
endmodule
`default_nettype wire

FILE: hdl/nst_sq_cell.sv
`default_nettype none
// one chain cell: square one axis difference and add it to the running sum
module nst_sq_cell (
    input  wire logic                              aclk,
    input  wire logic signed [nst_pkg::COORD_BITS-1:0] a,
    input  wire logic signed [nst_pkg::COORD_BITS-1:0] b,
    input  wire logic [nst_pkg::DIST_W-1:0]        sum_in,
    input  wire nst_pkg::cand_t                    cand_in,
    output logic [nst_pkg::DIST_W-1:0]             sum_out,
    output nst_pkg::cand_t                         cand_out
);
    import nst_pkg::*;
    logic signed [DIFF_W-1:0] d;
    logic [DIFF_W-1:0]        mag;
    logic [SQ_W-1:0]          sq;

    assign d   = DIFF_W'(a) - DIFF_W'(b);
    assign mag = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    assign sq  = SQ_W'(mag[SQ_W/2-1:0]) * SQ_W'(mag[SQ_W/2-1:0]);

    always_ff @(posedge aclk) begin
        sum_out  <= sum_in + DIST_W'(sq);
        cand_out <= cand_in;
    end
endmodule
`default_nettype wire

FILE: hdl/nst_cmp_cell.sv
`default_nettype none
// final cell: keep the later candidate on a tie
module nst_cmp_cell (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  clear,
    input  wire nst_pkg::cand_t        cand,
    input  wire logic [nst_pkg::DIST_W-1:0] sq_dist,
    output nst_pkg::best_t             best
);
    import nst_pkg::*;
    best_t best_reg;
    assign best = best_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            best_reg <= '0;
        end else if (cand.valid && (!best_reg.found || sq_dist <= best_reg.sq_dist)) begin
            best_reg <= {1'b1, cand.plane, cand.slot, cand.x, cand.y, cand.z, sq_dist};
        end
    end
endmodule
`default_nettype wire
